// ===== hw/rtl/bfm_pkg.sv =====
`timescale 1ns / 1ps
package bfm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int D2_W      = 22;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [16:0] ONE_Q     = 17'h1_0000;
  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd4;

  typedef struct packed {
    logic [D2_W-1:0]  d2;
    logic [31:0]      re;
    logic [31:0]      im;
  } bin_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDIV, ST_PCHK, ST_PMUL, ST_PRND, ST_GDIV, ST_SCALE
  } back_state_e;

endpackage

// ===== hw/rtl/bfm_fifo.sv =====
`timescale 1ns / 1ps
module bfm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bfm_pkg::bin_entry_t wdata_i,
  input  logic                pop_i,
  output bfm_pkg::bin_entry_t rdata_o,
  output logic                valid_o,
  output logic                full_o
);

  bfm_pkg::bin_entry_t mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;

endmodule

// ===== hw/rtl/bfm_front.sv =====
`timescale 1ns / 1ps
module bfm_front (
  input  logic                               start_i,
  input  logic                               full_i,
  input  logic [bfm_pkg::DIM_W-1:0]          rows_i,
  input  logic [bfm_pkg::DIM_W-1:0]          cols_i,
  input  logic [9:0]                         bin_row_i,
  input  logic [9:0]                         bin_col_i,
  input  logic signed [31:0]                 re_in_i,
  input  logic signed [31:0]                 im_in_i,
  output logic                               push_o,
  output bfm_pkg::bin_entry_t                entry_o
);

  logic [bfm_pkg::DIM_W-1:0] rows_c, cols_c;
  logic signed [10:0]        dr, dc;
  logic signed [21:0]        dr2, dc2;

  always_comb begin
    rows_c = (rows_i > bfm_pkg::MAX_DIM) ? bfm_pkg::MAX_DIM : rows_i;
    cols_c = (cols_i > bfm_pkg::MAX_DIM) ? bfm_pkg::MAX_DIM : cols_i;
    dr  = $signed({1'b0, bin_row_i}) - $signed({1'b0, rows_c[10:1]});
    dc  = $signed({1'b0, bin_col_i}) - $signed({1'b0, cols_c[10:1]});
    dr2 = 22'(dr * dr);
    dc2 = 22'(dc * dc);
    entry_o.d2 = 22'(dr2 + dc2);
    entry_o.re = re_in_i;
    entry_o.im = im_in_i;
    push_o = start_i && !full_i;
  end

endmodule

// ===== hw/rtl/bfm_back.sv =====
`timescale 1ns / 1ps
module bfm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  bfm_pkg::bin_entry_t        entry_i,
  output logic                       pop_o,
  input  logic [10:0]                cutoff_i,
  input  logic [5:0]                 order_i,
  input  logic                       high_pass_i,
  output logic                       done_o,
  output logic signed [31:0]         re_out_o,
  output logic signed [31:0]         im_out_o,
  output logic [16:0]                gain_o
);

  bfm_pkg::back_state_e state_q, state_d;
  logic [33:0] rem_q, rem_d, div_q, div_d, t;
  logic [31:0] num_q, num_d, quo_q, quo_d, ratio_q, ratio_d, p_q, p_d, pf;
  logic [5:0]  cnt_q, cnt_d, k_q, k_d;
  logic        sat_q, sat_d, ge, done_q, done_d;
  logic [63:0] m_q, m_d;
  logic [47:0] pr;
  logic [16:0] g_q, g_d;
  logic [31:0] re_q, re_d, im_q, im_d, re_out_q, re_out_d, im_out_q, im_out_d;
  logic [10:0] d0;
  logic [21:0] d0sq;
  logic [32:0] den, nn;
  logic signed [48:0] pre, pim;

  always_comb begin
    state_d = state_q;
    rem_d = rem_q; div_d = div_q; num_d = num_q; quo_d = quo_q;
    ratio_d = ratio_q; p_d = p_q; cnt_d = cnt_q; k_d = k_q; sat_d = sat_q;
    m_d = m_q; g_d = g_q; re_d = re_q; im_d = im_q;
    re_out_d = re_out_q; im_out_d = im_out_q; done_d = 1'b0; pop_o = 1'b0;
    d0   = (cutoff_i == 11'd0) ? 11'd1 : cutoff_i;
    d0sq = 22'(d0 * d0);
    t    = {rem_q[32:0], num_q[31]};
    ge   = t >= div_q;
    pf   = sat_q ? bfm_pkg::RATIO_MAX : p_q;
    den  = {1'b0, pf} + {16'd0, bfm_pkg::ONE_Q};
    nn   = 33'h1_0000_0000 + {1'b0, den[32:1]};
    pr   = 48'((m_q + 64'd32768) >> bfm_pkg::FRAC_BITS);
    pre  = 49'(($signed(re_q) * $signed({1'b0, g_q})) + 49'sd32768);
    pim  = 49'(($signed(im_q) * $signed({1'b0, g_q})) + 49'sd32768);
    unique case (state_q) inside
      bfm_pkg::ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          re_d  = entry_i.re;
          im_d  = entry_i.im;
          p_d   = {15'd0, bfm_pkg::ONE_Q};
          k_d   = 6'd0;
          sat_d = 1'b0;
          if ({16'd0, entry_i.d2[21:16]} >= d0sq) begin
            ratio_d = bfm_pkg::RATIO_MAX;
            state_d = bfm_pkg::ST_PCHK;
          end else begin
            rem_d   = {28'd0, entry_i.d2[21:16]};
            num_d   = {entry_i.d2[15:0], 16'd0};
            div_d   = {12'd0, d0sq};
            cnt_d   = 6'd32;
            state_d = bfm_pkg::ST_RDIV;
          end
        end
      end
      bfm_pkg::ST_RDIV, bfm_pkg::ST_GDIV: begin
        rem_d = ge ? t - div_q : t;
        quo_d = {quo_q[30:0], ge};
        num_d = {num_q[30:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          if (state_q == bfm_pkg::ST_RDIV) begin
            ratio_d = quo_d;
            state_d = bfm_pkg::ST_PCHK;
          end else begin
            g_d     = high_pass_i ? bfm_pkg::ONE_Q - quo_d[16:0] : quo_d[16:0];
            state_d = bfm_pkg::ST_SCALE;
          end
        end
      end
      bfm_pkg::ST_PCHK: begin
        if (sat_q || k_q == order_i) begin
          rem_d   = {18'd0, nn[32:17]};
          num_d   = {nn[16:0], 15'd0};
          div_d   = {1'b0, den};
          cnt_d   = 6'd17;
          state_d = bfm_pkg::ST_GDIV;
        end else begin
          state_d = bfm_pkg::ST_PMUL;
        end
      end
      bfm_pkg::ST_PMUL: begin
        m_d     = p_q * ratio_q;
        state_d = bfm_pkg::ST_PRND;
      end
      bfm_pkg::ST_PRND: begin
        if (pr >= {16'd0, bfm_pkg::RATIO_MAX}) begin
          sat_d = 1'b1;
        end else begin
          p_d = pr[31:0];
        end
        k_d     = k_q + 6'd1;
        state_d = bfm_pkg::ST_PCHK;
      end
      bfm_pkg::ST_SCALE: begin
        re_out_d = 32'(pre >>> bfm_pkg::FRAC_BITS);
        im_out_d = 32'(pim >>> bfm_pkg::FRAC_BITS);
        done_d   = 1'b1;
        state_d  = bfm_pkg::ST_IDLE;
      end
      default: state_d = bfm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfm_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; div_q <= div_d; num_q <= num_d; quo_q <= quo_d;
    ratio_q <= ratio_d; p_q <= p_d; cnt_q <= cnt_d; k_q <= k_d; sat_q <= sat_d;
    m_q <= m_d; g_q <= g_d; re_q <= re_d; im_q <= im_d;
    re_out_q <= re_out_d; im_out_q <= im_out_d;
  end

  assign done_o   = done_q;
  assign re_out_o = re_out_q;
  assign im_out_o = im_out_q;
  assign gain_o   = g_q;

endmodule

// ===== hw/rtl/butterworth_frequency_mask.sv =====
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// input    start_i / busy_o    bin_row_i bin_col_i re_in_i im_in_i
// result   done_o (strobe)     re_out_o im_out_o gain_o
// config   cfg_we_i            cfg_idx_i cfg_wdata_i
// In the back end a beat runs a 32-step ratio divide (skipped when the ratio
// saturates), check, multiply and round states per power multiply (n of them,
// n = filter_order, fewer once the power saturates), a 17-step gain divide and
// a scaling state, all on one shared divider; done_o rises in the next cycle.
// The front end computes the distance in the accept cycle into a 2-entry queue;
// busy_o is high while the queue is full. Reset restores register defaults.
module butterworth_frequency_mask (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [9:0]           bin_row_i,
  input  logic [9:0]           bin_col_i,
  input  logic signed [31:0]   re_in_i,
  input  logic signed [31:0]   im_in_i,
  output logic                 done_o,
  output logic signed [31:0]   re_out_o,
  output logic signed [31:0]   im_out_o,
  output logic [16:0]          gain_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [10:0]          cfg_wdata_i
);

  logic [10:0] cutoff_q, rows_q, cols_q;
  logic [5:0]  order_q;
  logic        high_q;
  logic        push, pop, fifo_valid, full;
  bfm_pkg::bin_entry_t wentry, rentry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 11'd200;
      order_q  <= 6'd20;
      high_q   <= 1'b0;
      rows_q   <= 11'd1024;
      cols_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfm_pkg::REG_CUTOFF: cutoff_q <= cfg_wdata_i;
        bfm_pkg::REG_ORDER:  order_q  <= cfg_wdata_i[5:0];
        bfm_pkg::REG_HIGH:   high_q   <= cfg_wdata_i[0];
        bfm_pkg::REG_ROWS:   rows_q   <= cfg_wdata_i;
        bfm_pkg::REG_COLS:   cols_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bfm_front u_front (
    .start_i(start_i), .full_i(full), .rows_i(rows_q), .cols_i(cols_q),
    .bin_row_i(bin_row_i), .bin_col_i(bin_col_i), .re_in_i(re_in_i),
    .im_in_i(im_in_i), .push_o(push), .entry_o(wentry)
  );

  bfm_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .wdata_i(wentry),
    .pop_i(pop), .rdata_o(rentry), .valid_o(fifo_valid), .full_o(full)
  );

  bfm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(fifo_valid), .entry_i(rentry),
    .pop_o(pop), .cutoff_i(cutoff_q), .order_i(order_q), .high_pass_i(high_q),
    .done_o(done_o), .re_out_o(re_out_o), .im_out_o(im_out_o), .gain_o(gain_o)
  );

  assign busy_o = full;

endmodule

// ===== hw/rtl/bfm_checker.sv =====
`timescale 1ns / 1ps
module bfm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [31:0] re_out_o,
  input logic signed [31:0] im_out_o,
  input logic [16:0]        gain_o
);

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> gain_o <= bfm_pkg::ONE_Q) else $error("gain above one");

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result beats");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && gain_o == 17'd0) |-> (re_out_o == 32'sd0 && im_out_o == 32'sd0))
    else $error("nonzero output at zero gain");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!busy_o && !done_o)) else $error("activity after reset");

endmodule

bind butterworth_frequency_mask bfm_checker u_bfm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(busy_o), .done_o(done_o),
  .re_out_o(re_out_o), .im_out_o(im_out_o), .gain_o(gain_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 250;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [16:0]        gain;
  } filtered_bin_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [9:0]         bin_row_i;
  logic [9:0]         bin_col_i;
  logic signed [31:0] re_in_i;
  logic signed [31:0] im_in_i;
  logic               done_o;
  logic signed [31:0] re_out_o;
  logic signed [31:0] im_out_o;
  logic [16:0]        gain_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [10:0]        cfg_wdata_i;

  // mirror of the block's registers
  logic [10:0] cutoff_q;
  logic [5:0]  order_q;
  logic        high_q;
  logic [10:0] rows_q;
  logic [10:0] cols_q;

  filtered_bin_t pending_bins[$];
  int errors;
  int idle_pct;
  int stall_count;

  butterworth_frequency_mask dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint centre_of(logic [10:0] size);
    logic [10:0] s;
    s = (size > bfm_pkg::MAX_DIM) ? bfm_pkg::MAX_DIM : size;
    return longint'(s / 2);
  endfunction

  function automatic logic [16:0] butterworth_gain(logic [9:0] row, logic [9:0] col);
    longint dr, dc;
    longint unsigned d2, d0, ratio, p, g;
    logic [127:0] m;
    bit sat;
    int k;
    dr = longint'(row) - centre_of(rows_q);
    dc = longint'(col) - centre_of(cols_q);
    d2 = dr * dr + dc * dc;
    d0 = (cutoff_q == 0) ? 1 : cutoff_q;
    ratio = (d2 << bfm_pkg::FRAC_BITS) / (d0 * d0);
    if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    p = 64'h1_0000;
    sat = 0;
    for (k = 0; k < int'(order_q) && !sat; k++) begin
      m = {64'd0, p} * {64'd0, ratio};
      if (m > 128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_7FFF) begin
        sat = 1;
      end else begin
        p = (m[63:0] + 64'd32768) >> bfm_pkg::FRAC_BITS;
        if (p >= 64'hFFFF_FFFF) sat = 1;
      end
    end
    if (sat) p = 64'hFFFF_FFFF;
    g = (64'h1_0000_0000 + (64'h1_0000 + p) / 2) / (64'h1_0000 + p);
    if (high_q) g = 64'h1_0000 - g;
    return g[16:0];
  endfunction

  function automatic logic [31:0] apply_gain(logic signed [31:0] x, logic [16:0] g);
    longint prod;
    prod = longint'(x) * longint'(g) + 64'sd32768;
    prod = prod >>> bfm_pkg::FRAC_BITS;
    return prod[31:0];
  endfunction

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    filtered_bin_t w;
    if (rst_ni && done_o) begin
      if (pending_bins.size() == 0) begin
        $display("unexpected beat at %0t", $realtime);
        errors++;
      end else begin
        w = pending_bins.pop_front();
        if (re_out_o !== w.re) report("re_out", w.re, re_out_o);
        if (im_out_o !== w.im) report("im_out", w.im, im_out_o);
        if (gain_o !== w.gain) report("gain", 32'(w.gain), 32'(gain_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_bin(logic [9:0] row, logic [9:0] col, logic [31:0] re, logic [31:0] im);
    filtered_bin_t w;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    bin_row_i <= row;
    bin_col_i <= col;
    re_in_i   <= re;
    im_in_i   <= im;
    do @(posedge clk_i); while (busy_o);
    w.gain = butterworth_gain(row, col);
    w.re   = apply_gain(re, w.gain);
    w.im   = apply_gain(im, w.gain);
    pending_bins.push_back(w);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    wait (pending_bins.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [10:0] cutoff, logic [5:0] order, logic hp,
                           logic [10:0] rows, logic [10:0] cols);
    drain();
    write_reg(bfm_pkg::REG_CUTOFF, cutoff);
    write_reg(bfm_pkg::REG_ORDER, 11'(order));
    write_reg(bfm_pkg::REG_HIGH, 11'(hp));
    write_reg(bfm_pkg::REG_ROWS, rows);
    write_reg(bfm_pkg::REG_COLS, cols);
    cfg_we_i <= 1'b0;
    cutoff_q = cutoff;
    order_q  = order;
    high_q   = hp;
    rows_q   = rows;
    cols_q   = cols;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_bin(10'd512, 10'd512, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(10'd512, 10'd712, 32'd1000, -32'sd1000);
    send_bin(10'd0, 10'd0, 32'hFFFF_FFFF, 32'd1);
    send_bin(10'd1023, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_field_extremes();
    configure(11'd2047, 6'd32, 1'b0, 11'd1024, 11'd1024);
    send_bin(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_bin(10'd1023, 10'd0, 32'h8000_0000, 32'h8000_0000);
    configure(11'd1, 6'd1, 1'b1, 11'd2, 11'd2);
    send_bin(10'd1, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(10'd1, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bin(10'd1023, 10'd1023, 32'h1234_5678, 32'hDEAD_BEEF);
  endtask

  task automatic test_special_cases();
    // zero cutoff, zero order
    configure(11'd0, 6'd0, 1'b0, 11'd0, 11'd1);
    send_bin(10'd0, 10'd0, 32'd3, -32'sd3);
    send_bin(10'd5, 10'd7, 32'h7FFF_FFFF, 32'h8000_0000);
    // order above 32, oversized spectrum
    configure(11'd40, 6'd63, 1'b1, 11'd2047, 11'd1500);
    send_bin(10'd512, 10'd530, 32'd65535, -32'sd65535);
    send_bin(10'd512, 10'd552, 32'd65536, -32'sd65536);
    send_bin(10'd540, 10'd512, 32'd12345, 32'd1);
    configure(11'd40, 6'd33, 1'b0, 11'd1025, 11'd3);
    send_bin(10'd512, 10'd39, 32'h4000_0000, 32'hC000_0000);
    send_bin(10'd520, 10'd1, 32'd32767, -32'sd32768);
  endtask

  task automatic test_random();
    int ph, blk, n;
    int pct[3] = '{38, 75, 0};
    int c, r0, c0, rr, cc;
    logic [10:0] rows, cols, cut;
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      for (blk = 0; blk < 10; blk++) begin
        rows = ($urandom_range(7) == 0) ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(2, 1024));
        cols = ($urandom_range(7) == 0) ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(2, 1024));
        cut = ($urandom_range(3) == 0) ? 11'($urandom_range(0, 2047))
                                       : 11'($urandom_range(1, 300));
        configure(cut, ($urandom_range(5) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 32)),
                  1'($urandom_range(1)), rows, cols);
        c  = (cut == 0) ? 1 : int'(cut);
        r0 = int'(centre_of(rows));
        c0 = int'(centre_of(cols));
        for (n = 0; n < 65; n++) begin
          if ($urandom_range(3) == 0) begin
            rr = $urandom_range(0, 1023);
            cc = $urandom_range(0, 1023);
          end else begin
            rr = r0 + $urandom_range(0, 4 * c) - 2 * c;
            cc = c0 + $urandom_range(0, 4 * c) - 2 * c;
            rr = (rr < 0) ? 0 : (rr > 1023) ? 1023 : rr;
            cc = (cc < 0) ? 0 : (cc > 1023) ? 1023 : cc;
          end
          send_bin(10'(rr), 10'(cc), $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    bin_row_i   = '0;
    bin_col_i   = '0;
    re_in_i     = '0;
    im_in_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    errors      = 0;
    idle_pct    = 0;
    stall_count = 0;
    cutoff_q    = 11'd200;
    order_q     = 6'd20;
    high_q      = 1'b0;
    rows_q      = 11'd1024;
    cols_q      = 11'd1024;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_random();
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
